### sv/rbst_pkg.sv
package rbst_pkg;

    // Default number format: signed Q16.16
    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;

    // Ray geometry: three axes, two slab bounds per axis, one divider lane per bound
    localparam int NUM_AXES  = 3;
    localparam int NUM_LANES = 2 * NUM_AXES;

    // Stages of the merge that follows the divider lanes
    localparam int MERGE_STAGES = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_T_LOWER  = 3'd6,
        REG_T_UPPER  = 3'd7
    } t_cfg_reg;

    // Per-axis status handed from the front end to the merge
    typedef struct packed {
        logic [NUM_AXES-1:0] dzero;   // direction component is zero
        logic [NUM_AXES-1:0] zmiss;   // zero direction and origin outside the slab
    } t_axis_flags;

endpackage

### sv/rbst_lane.sv
// One slab distance: (bound - origin) * 2^FRAC / dir, truncated and saturated.
// Restoring division, one quotient bit per step stage.
module rbst_lane #(
    parameter int COORD_W = rbst_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_W  = rbst_pkg::DEF_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic [COORD_W+1:0]        i_en,
    input  logic [COORD_W-1:0]        i_bound,
    input  logic [COORD_W-1:0]        i_org,
    input  logic [COORD_W-1:0]        i_dm,
    input  logic                      i_dneg,
    output logic signed [COORD_W-1:0] o_dist
);

    localparam int DW   = COORD_W + 1;
    localparam int NW   = COORD_W + 1 + FRAC_W;
    localparam int HW   = FRAC_W + 2;
    localparam int CW   = (HW > COORD_W) ? HW : COORD_W;
    localparam int QW   = COORD_W - 1;
    localparam int LAST = COORD_W + 1;

    // Front: exact difference and its magnitude
    logic [DW-1:0] n_diff;
    logic [DW-1:0] n_mag;
    logic [DW-1:0] r_mag;
    logic          r_neg0;

    always_comb begin
        n_diff = {i_bound[COORD_W-1], i_bound} - {i_org[COORD_W-1], i_org};
        n_mag  = n_diff[DW-1] ? (DW'(0) - n_diff) : n_diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mag  <= n_mag;
            r_neg0 <= n_diff[DW-1] ^ i_dneg;
        end
    end

    // Division pipeline registers, stage 1 is the setup, stage COORD_W the last bit
    logic [QW-1:0] r_rem [1:COORD_W];
    logic [QW-1:0] r_low [1:COORD_W];
    logic [QW-1:0] r_q   [1:COORD_W];
    logic          r_sat [1:COORD_W];
    logic          r_sgn [1:COORD_W];

    // Setup: saturate when the quotient reaches 2^(COORD_W-1)
    logic [NW-1:0] n_num;
    logic [CW-1:0] n_hi;
    logic          n_sat;

    always_comb begin
        n_num = NW'(r_mag) << FRAC_W;
        n_hi  = CW'(n_num >> (COORD_W - 1));
        n_sat = n_hi >= CW'(i_dm);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rem[1] <= n_sat ? '0 : n_hi[QW-1:0];
            r_low[1] <= n_num[QW-1:0];
            r_q[1]   <= '0;
            r_sat[1] <= n_sat;
            r_sgn[1] <= r_neg0;
        end
    end

    // One quotient bit per stage
    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [COORD_W-1:0] n_try;
        logic               n_ge;

        always_comb begin
            n_try = {r_rem[j+1], r_low[j+1][QW-1-j]};
            n_ge  = n_try >= i_dm;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j+2]) begin
                r_rem[j+2] <= n_ge ? QW'(n_try - i_dm) : n_try[QW-1:0];
                r_low[j+2] <= r_low[j+1];
                r_q[j+2]   <= {r_q[j+1][QW-2:0], n_ge};
                r_sat[j+2] <= r_sat[j+1];
                r_sgn[j+2] <= r_sgn[j+1];
            end
        end
    end

    // Apply sign and clamp to the signed range
    logic [COORD_W-1:0] n_dist;
    logic [COORD_W-1:0] r_dist;

    always_comb begin
        if (r_sat[COORD_W]) begin
            n_dist = r_sgn[COORD_W] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
        end else if (r_sgn[COORD_W]) begin
            n_dist = COORD_W'(0) - {1'b0, r_q[COORD_W]};
        end else begin
            n_dist = {1'b0, r_q[COORD_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[LAST]) begin
            r_dist <= n_dist;
        end
    end

    assign o_dist = $signed(r_dist);

endmodule

### sv/rbst_merge.sv
// Order the slab distances per axis, narrow the interval, decide hit or miss.
module rbst_merge #(
    parameter int COORD_W = rbst_pkg::DEF_COORD_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [rbst_pkg::MERGE_STAGES-1:0] i_en,
    input  logic signed [COORD_W-1:0] i_dist [rbst_pkg::NUM_LANES],
    input  rbst_pkg::t_axis_flags     i_flags,
    input  logic signed [COORD_W-1:0] i_t_lower,
    input  logic signed [COORD_W-1:0] i_t_upper,
    output logic                      o_hit
);

    localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // Near and far per axis; a zero direction sets no limit
    logic signed [COORD_W-1:0] n_near [rbst_pkg::NUM_AXES];
    logic signed [COORD_W-1:0] n_far  [rbst_pkg::NUM_AXES];
    logic signed [COORD_W-1:0] r_near [rbst_pkg::NUM_AXES];
    logic signed [COORD_W-1:0] r_far  [rbst_pkg::NUM_AXES];
    logic                      r_zm_a;

    always_comb begin
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            if (i_flags.dzero[a]) begin
                n_near[a] = T_MIN;
                n_far[a]  = T_MAX;
            end else if (i_dist[2*a] < i_dist[2*a+1]) begin
                n_near[a] = i_dist[2*a];
                n_far[a]  = i_dist[2*a+1];
            end else begin
                n_near[a] = i_dist[2*a+1];
                n_far[a]  = i_dist[2*a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_near <= n_near;
            r_far  <= n_far;
            r_zm_a <= |i_flags.zmiss;
        end
    end

    // Narrow the interval
    logic signed [COORD_W-1:0] n_lo;
    logic signed [COORD_W-1:0] n_up;
    logic signed [COORD_W-1:0] r_lo;
    logic signed [COORD_W-1:0] r_up;
    logic                      r_zm_b;

    always_comb begin
        n_lo = i_t_lower;
        n_up = i_t_upper;
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            if (r_near[a] > n_lo) begin
                n_lo = r_near[a];
            end
            if (r_far[a] < n_up) begin
                n_up = r_far[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_lo   <= n_lo;
            r_up   <= n_up;
            r_zm_b <= r_zm_a;
        end
    end

    // Output word: hit when no axis missed and the interval is not empty
    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_en[2]) begin
            r_hit <= !r_zm_b && (r_lo < r_up);
        end
    end

    assign o_hit = r_hit;

endmodule

### sv/ray_box_slab_test.sv
// Box and ray coordinates are signed fixed point, Q16.16 by default.
// Throughput: one box per cycle while the hit channel is not stalled; six divider lanes
// each retire one quotient bit per stage in COORD_WIDTH + 2 lane stages, then the merge.
// A stalled output holds only the full tail of the pipeline; bubbles still fill.
// Reset (synchronous, active low) empties the pipeline and loads the default ray.
module ray_box_slab_test #(
    parameter int COORD_WIDTH = rbst_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = rbst_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [rbst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    // box words
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_z,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_z,
    // hit words
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit
);

    localparam int NA  = rbst_pkg::NUM_AXES;
    localparam int NL  = rbst_pkg::NUM_LANES;
    localparam int LS  = COORD_WIDTH + 2;
    localparam int NST = LS + rbst_pkg::MERGE_STAGES;
    localparam int TOP = NST - 1;

    // Configuration registers
    logic [COORD_WIDTH-1:0] r_org [NA];
    logic [COORD_WIDTH-1:0] r_dir [NA];
    logic [COORD_WIDTH-1:0] r_tl;
    logic [COORD_WIDTH-1:0] r_tu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NA; a++) begin
                r_org[a] <= '0;
                r_dir[a] <= (a == 0) ? (COORD_WIDTH'(1) << FRAC_BITS) : '0;
            end
            r_tl     <= '0;
            r_tu     <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else if (i_cfg_we) begin
            case (rbst_pkg::t_cfg_reg'(i_cfg_idx))
                rbst_pkg::REG_ORIGIN_X: r_org[0] <= i_cfg_data;
                rbst_pkg::REG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                rbst_pkg::REG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                rbst_pkg::REG_DIR_X:    r_dir[0] <= i_cfg_data;
                rbst_pkg::REG_DIR_Y:    r_dir[1] <= i_cfg_data;
                rbst_pkg::REG_DIR_Z:    r_dir[2] <= i_cfg_data;
                rbst_pkg::REG_T_LOWER:  r_tl     <= i_cfg_data;
                rbst_pkg::REG_T_UPPER:  r_tu     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Divisor magnitude, sign; user holds them steady with words in flight (unchecked)
    logic [COORD_WIDTH-1:0] w_dm    [NA];
    logic [NA-1:0]          w_dneg;
    logic [NA-1:0]          w_dzero;

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            w_dneg[a]  = r_dir[a][COORD_WIDTH-1];
            w_dm[a]    = w_dneg[a] ? (COORD_WIDTH'(0) - r_dir[a]) : r_dir[a];
            w_dzero[a] = r_dir[a] == '0;
        end
    end

    // Stage enables: a stage advances when it is empty or its successor advances
    logic [NST-1:0] w_en;
    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;

    assign w_en[TOP] = !r_vld[TOP] || i_ready;
    for (genvar k = 0; k < TOP; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NST; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[TOP];

    // Slab bounds, two lanes per axis
    logic [COORD_WIDTH-1:0] w_bound [NL];

    assign w_bound[0] = i_box_min_x;
    assign w_bound[1] = i_box_max_x;
    assign w_bound[2] = i_box_min_y;
    assign w_bound[3] = i_box_max_y;
    assign w_bound[4] = i_box_min_z;
    assign w_bound[5] = i_box_max_z;

    // Zero-direction miss, carried alongside the lanes
    logic [NA-1:0] n_zm;
    logic [NA-1:0] r_zm [LS];

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            n_zm[a] = w_dzero[a]
                && (($signed(r_org[a]) < $signed(w_bound[2*a]))
                    || ($signed(w_bound[2*a+1]) < $signed(r_org[a])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_zm[0] <= n_zm;
        end
        for (int k = 1; k < LS; k++) begin
            if (w_en[k]) begin
                r_zm[k] <= r_zm[k-1];
            end
        end
    end

    // Divider lanes
    logic signed [COORD_WIDTH-1:0] w_dist [NL];

    for (genvar l = 0; l < NL; l++) begin : g_lane
        rbst_lane #(
            .COORD_W (COORD_WIDTH),
            .FRAC_W  (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en[LS-1:0]),
            .i_bound (w_bound[l]),
            .i_org   (r_org[l/2]),
            .i_dm    (w_dm[l/2]),
            .i_dneg  (w_dneg[l/2]),
            .o_dist  (w_dist[l])
        );
    end

    // Merge
    rbst_pkg::t_axis_flags w_flags;

    assign w_flags.dzero = w_dzero;
    assign w_flags.zmiss = r_zm[LS-1];

    rbst_merge #(
        .COORD_W (COORD_WIDTH)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en[TOP:LS]),
        .i_dist    (w_dist),
        .i_flags   (w_flags),
        .i_t_lower ($signed(r_tl)),
        .i_t_upper ($signed(r_tu)),
        .o_hit     (o_hit)
    );

    // Checks
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input stalled while a pipeline stage is empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    a_count_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_vld) == $past($countones(r_vld))
            + int'($past(i_valid && o_ready)) - int'($past(o_valid && i_ready))))
        else $error("words lost or duplicated in the pipeline");

endmodule

### tb/sv/ray_box_slab_test_tb.sv
module ray_box_slab_test_tb;
    import rbst_pkg::*;

    localparam int     COORD_W    = DEF_COORD_WIDTH;
    localparam int     FRAC_W     = DEF_FRAC_BITS;
    localparam int     NUM_REGS   = 2 ** CFG_IDX_W;
    localparam int     DRAIN      = COORD_W + 5 + 8;
    localparam longint T_MAX      = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint T_MIN      = -(longint'(1) <<< (COORD_W - 1));
    localparam int     MAX_REPORT = 10;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t min_x;
        coord_t max_x;
        coord_t min_y;
        coord_t max_y;
        coord_t min_z;
        coord_t max_z;
    } box_t;

    typedef struct {
        logic        hit;
        int unsigned seq;
    } hit_word_t;

    logic   i_clk      = 1'b0;
    logic   i_rst_n    = 1'b0;
    logic   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [COORD_W-1:0]   i_cfg_data = '0;
    logic   i_valid    = 1'b0;
    logic   o_ready;
    coord_t i_box_min_x, i_box_max_x, i_box_min_y, i_box_max_y, i_box_min_z, i_box_max_z;
    logic   o_valid;
    logic   i_ready    = 1'b0;
    logic   o_hit;

    box_t        drv_box = '0;
    box_t        box_queue[$];
    hit_word_t   hit_expect[$];
    coord_t      ray_cfg[NUM_REGS];
    bit          gaps_on = 1'b1;
    int unsigned boxes_sent   = 0;
    int unsigned hits_seen    = 0;
    int unsigned misses_seen  = 0;
    int unsigned errors       = 0;
    int unsigned ray_settings = 0;

    assign i_box_min_x = drv_box.min_x;
    assign i_box_max_x = drv_box.max_x;
    assign i_box_min_y = drv_box.min_y;
    assign i_box_max_y = drv_box.max_y;
    assign i_box_min_z = drv_box.min_z;
    assign i_box_max_z = drv_box.max_z;

    ray_box_slab_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_box_min_x (i_box_min_x),
        .i_box_max_x (i_box_max_x),
        .i_box_min_y (i_box_min_y),
        .i_box_max_y (i_box_max_y),
        .i_box_min_z (i_box_min_z),
        .i_box_max_z (i_box_max_z),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hit       (o_hit)
    );

    always #4 i_clk = ~i_clk;

    // Entry or exit distance along one axis: exact quotient, truncated, saturated
    function automatic coord_t slab_dist(coord_t bound, coord_t org, coord_t dirc);
        longint num;
        longint q;
        num = (longint'(bound) - longint'(org)) * (longint'(1) <<< FRAC_W);
        q = num / longint'(dirc);
        if (q > T_MAX) q = T_MAX;
        if (q < T_MIN) q = T_MIN;
        return coord_t'(q);
    endfunction

    // Narrow the ray interval slab by slab; an empty interval is a miss
    function automatic logic slab_hit(box_t b);
        coord_t org[3];
        coord_t dirv[3];
        coord_t bmin[3];
        coord_t bmax[3];
        coord_t lo, hi, t0, t1;
        org  = '{ray_cfg[REG_ORIGIN_X], ray_cfg[REG_ORIGIN_Y], ray_cfg[REG_ORIGIN_Z]};
        dirv = '{ray_cfg[REG_DIR_X], ray_cfg[REG_DIR_Y], ray_cfg[REG_DIR_Z]};
        bmin = '{b.min_x, b.min_y, b.min_z};
        bmax = '{b.max_x, b.max_y, b.max_z};
        lo = ray_cfg[REG_T_LOWER];
        hi = ray_cfg[REG_T_UPPER];
        for (int a = 0; a < 3; a++) begin
            if (dirv[a] == 0) begin
                // parallel to the slab: origin must sit inside the closed range
                if (org[a] < bmin[a] || bmax[a] < org[a]) return 1'b0;
            end else begin
                t0 = slab_dist(bmin[a], org[a], dirv[a]);
                t1 = slab_dist(bmax[a], org[a], dirv[a]);
                if (t0 > t1) begin
                    coord_t sw;
                    sw = t0;
                    t0 = t1;
                    t1 = sw;
                end
                if (t0 > lo) lo = t0;
                if (t1 < hi) hi = t1;
            end
            if (!(lo < hi)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Drive box words; record the expected hit when a word is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                hit_expect.push_back('{slab_hit(drv_box), boxes_sent});
                boxes_sent++;
            end
            if (box_queue.size() != 0 && !(gaps_on && $urandom_range(99) < 6)) begin
                drv_box <= box_queue.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Stall the hit channel at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(gaps_on && $urandom_range(99) < 6);
        end
    end

    // Compare each hit word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (hit_expect.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORT)
                    $display("ERROR: hit word %0b with no box outstanding", o_hit);
            end else begin
                hit_word_t w;
                w = hit_expect.pop_front();
                if (o_hit !== w.hit) begin
                    errors++;
                    if (errors <= MAX_REPORT)
                        $display("ERROR: box %0d hit expected %0b actual %0b",
                                 w.seq, w.hit, o_hit);
                end
                if (w.hit) hits_seen++;
                else misses_seen++;
            end
        end
    end

    task automatic write_reg(input t_cfg_reg r, input coord_t v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= v;
        ray_cfg[r] = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_ray(input coord_t ox, oy, oz, dx, dy, dz, tl, tu);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_T_LOWER, tl);
        write_reg(REG_T_UPPER, tu);
        ray_settings++;
    endtask

    // Wait for every hit word to come back, then let the pipeline drain
    task automatic settle();
        do @(posedge i_clk);
        while (box_queue.size() != 0 || i_valid || hit_expect.size() != 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic queue_box(input coord_t mnx, mxx, mny, mxy, mnz, mxz);
        box_queue.push_back('{mnx, mxx, mny, mxy, mnz, mxz});
    endtask

    // Signed value spread around zero over the given number of bits
    function automatic coord_t spread(int bits);
        return coord_t'(($urandom & ((32'd1 << bits) - 1)) - (32'd1 << (bits - 1)));
    endfunction

    function automatic coord_t random_dir();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return coord_t'($urandom);
            3:       return spread(8);
            default: return spread(18);
        endcase
    endfunction

    // Slab near the origin on one axis; sometimes noise or inverted
    task automatic random_slab(input coord_t org, output coord_t lo, output coord_t hi);
        int bits;
        int mode;
        mode = $urandom_range(99);
        bits = $urandom_range(30, 4);
        if (mode < 8) begin
            lo = coord_t'($urandom);
            hi = coord_t'($urandom);
        end else begin
            lo = org + spread(bits);
            hi = lo + coord_t'($urandom & ((32'd1 << bits) - 1));
            if (mode < 14) begin
                coord_t sw;
                sw = lo;
                lo = hi;
                hi = sw;
            end
        end
    endtask

    task automatic random_ray();
        coord_t o[3];
        coord_t tl, tu;
        for (int a = 0; a < 3; a++)
            o[a] = ($urandom_range(3) == 0) ? coord_t'($urandom) : spread(20);
        case ($urandom_range(3))
            0: tl = '0;
            1: tl = spread(20);
            2: tl = coord_t'($urandom);
            default: tl = coord_t'(T_MIN);
        endcase
        case ($urandom_range(4))
            0, 1: tu = coord_t'(T_MAX);
            2:    tu = coord_t'($urandom_range(32'h4000_0000, 1));
            3:    tu = coord_t'($urandom);
            default: tu = tl;
        endcase
        load_ray(o[0], o[1], o[2], random_dir(), random_dir(), random_dir(), tl, tu);
    endtask

    // Limit on the whole run
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        box_t b;
        coord_t one, cmax, cmin;
        one  = coord_t'(65536);
        cmax = coord_t'(T_MAX);
        cmin = coord_t'(T_MIN);

        // hold the default ray until reset lets go
        ray_cfg[REG_ORIGIN_X] = '0;
        ray_cfg[REG_ORIGIN_Y] = '0;
        ray_cfg[REG_ORIGIN_Z] = '0;
        ray_cfg[REG_DIR_X]    = one;
        ray_cfg[REG_DIR_Y]    = '0;
        ray_cfg[REG_DIR_Z]    = '0;
        ray_cfg[REG_T_LOWER]  = '0;
        ray_cfg[REG_T_UPPER]  = cmax;
        ray_settings = 1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default ray along +x
        queue_box(one, 2 * one, -one, one, -one, one);
        queue_box(one, 2 * one, one, 2 * one, -one, one);
        queue_box(one, 2 * one, one, -one, -one, one);
        queue_box(cmin, cmax, cmin, cmax, cmin, cmax);
        queue_box('0, '0, '0, '0, '0, '0);
        queue_box(-5 * one, -2 * one, -one, one, -one, one);
        queue_box(2 * one, one, -one, one, -one, one);
        queue_box(one, 2 * one, '0, '0, '0, '0);
        settle();

        // empty starting interval
        load_ray('0, '0, '0, one, one, one, 100, 100);
        queue_box(-one, one, -one, one, -one, one);
        settle();
        write_reg(REG_T_UPPER, -one);
        queue_box(-one, one, -one, one, -one, one);
        settle();

        // tiny direction: quotients saturate both ways
        load_ray(cmin, cmin, cmin, 1, 1, -1, cmin, cmax);
        queue_box(cmin, cmax, cmin, cmax, cmin, cmax);
        queue_box(cmax, cmax, cmin, cmax, cmin, cmax);
        queue_box(cmin, cmax, cmin, cmax, cmax, cmax);
        settle();

        // most negative direction from the far corner
        load_ray(cmax, cmax, cmax, cmin, cmin, cmin, cmin, cmax);
        queue_box(cmin, cmax, cmin, cmax, cmin, cmax);
        queue_box(cmin, cmin, cmin, cmin, cmin, cmin);
        queue_box(cmax, cmax, cmax, cmax, cmax, cmax);
        settle();

        // negative and fractional directions
        load_ray(one, -one, '0, -one, -(one / 2), 2 * one, -cmax, cmax);
        queue_box(-3 * one, -2 * one, -4 * one, -3 * one, 4 * one, 5 * one);
        queue_box(-3 * one, -2 * one, -4 * one, -3 * one, -5 * one, -4 * one);
        queue_box(2 * one, 3 * one, 2 * one, one, '0, one);
        settle();

        // random rays, random boxes; one phase without any gaps
        for (int ph = 0; ph < 14; ph++) begin
            random_ray();
            gaps_on = (ph != 4);
            repeat (132) begin
                random_slab(ray_cfg[REG_ORIGIN_X], b.min_x, b.max_x);
                random_slab(ray_cfg[REG_ORIGIN_Y], b.min_y, b.max_y);
                random_slab(ray_cfg[REG_ORIGIN_Z], b.min_z, b.max_z);
                box_queue.push_back(b);
            end
            settle();
        end

        $display("Tested %0d boxes against %0d ray settings.", boxes_sent, ray_settings);
        $display("Results: %0d hits, %0d misses, %0d errors.", hits_seen, misses_seen, errors);
        if (errors == 0 && hit_expect.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
sv/rbst_pkg.sv
sv/rbst_lane.sv
sv/rbst_merge.sv
sv/ray_box_slab_test.sv
tb/sv/ray_box_slab_test_tb.sv
